// ----- rtl/lcdseq_pkg.sv -----
`timescale 1ns / 1ps

package lcdseq_pkg;

    localparam int unsigned HOLD_W = 16;
    localparam logic [HOLD_W-1:0] PULSE_HOLD_RESET = 16'd3600;

    // request kinds
    localparam logic [1:0] FUNC_CMD     = 2'd0;
    localparam logic [1:0] FUNC_DATA    = 2'd1;
    localparam logic [1:0] FUNC_CURSOR  = 2'd2;
    localparam logic [1:0] FUNC_STARTUP = 2'd3;

    // start-up program: bytes 0..4, extra wait after every byte but the first
    localparam logic [2:0] STARTUP_FIRST = 3'd0;
    localparam logic [2:0] STARTUP_LAST  = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] value;
        logic [1:0] row;
        logic [3:0] col;
    } lcdseq_in_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       enable;
        logic       wait_ms;
        logic       last;
    } lcdseq_out_t;

    // one control word per pin phase
    typedef struct packed {
        logic hi_sel;    // drive the high nibble of the byte register
        logic en;        // EN level
        logic byte_end;  // last phase of a byte: loop or finish
    } lcdseq_uop_t;

    function automatic lcdseq_uop_t ucode(input logic [1:0] pc);
        lcdseq_uop_t w;
        unique case (pc)
            2'd0:    w = '{hi_sel: 1'b1, en: 1'b1, byte_end: 1'b0};
            2'd1:    w = '{hi_sel: 1'b1, en: 1'b0, byte_end: 1'b0};
            2'd2:    w = '{hi_sel: 1'b0, en: 1'b1, byte_end: 1'b0};
            default: w = '{hi_sel: 1'b0, en: 1'b0, byte_end: 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] startup_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        unique case (row)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h90;
            default: b = 8'hD0;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/char_lcd_nibble_write_sequencer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_stall  lcdseq_in_t  (func, value, row, col)
// out       out  out_valid/out_stall lcdseq_out_t (reg_select, nibble, enable, wait_ms, last)
// cfg       in   cfg_valid/cfg_ready cfg_data: pulse_hold
//
// A byte request gives 4 pin phases, start-up gives 20; each phase is held by
// the hold counter, loaded from pulse_hold (also across requests), longer if
// out stalls. With the hold run out, the request, then its first phase, is registered.
// Reset leaves the sequencer idle and pulse_hold at 3600.
// in_stall is high while a request is being sequenced; the last phase may
// still sit in the output register while the next request is accepted.

module char_lcd_nibble_write_sequencer
    import lcdseq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lcdseq_in_t         in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lcdseq_out_t        out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [HOLD_W-1:0]  cfg_data
);

    logic              busy_reg,      busy_next;
    logic [1:0]        pc_reg,        pc_next;
    logic              init_reg,      init_next;
    logic [2:0]        idx_reg,       idx_next;
    logic [HOLD_W-1:0] hold_reg,      hold_next;
    logic [HOLD_W-1:0] pulse_hold_reg, pulse_hold_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg,      byte_next;
    logic              rs_reg,        rs_next;
    lcdseq_out_t       out_reg,       out_next;

    lcdseq_uop_t uop;
    logic        in_take;
    logic        emit;
    logic        more_bytes;
    logic [2:0]  idx_inc;

    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign in_take    = in_valid && !busy_reg;
    assign uop        = ucode(pc_reg);
    assign more_bytes = init_reg && (idx_reg != STARTUP_LAST);
    assign idx_inc    = idx_reg + 3'd1;
    assign emit       = busy_reg && (hold_reg == '0) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        busy_next       = busy_reg;
        pc_next         = pc_reg;
        init_next       = init_reg;
        idx_next        = idx_reg;
        hold_next       = hold_reg;
        pulse_hold_next = pulse_hold_reg;
        byte_next       = byte_reg;
        rs_next         = rs_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_valid)
        begin
            pulse_hold_next = cfg_data;
        end

        if (hold_reg != '0)
        begin
            hold_next = hold_reg - 1'b1;
        end

        if (in_take)
        begin
            busy_next = 1'b1;
            pc_next   = 2'd0;
            idx_next  = STARTUP_FIRST;
            init_next = (in_data.func == FUNC_STARTUP);
            rs_next   = (in_data.func == FUNC_DATA);
            unique case (in_data.func)
                FUNC_CURSOR:  byte_next = row_base(in_data.row) | {4'h0, in_data.col};
                FUNC_STARTUP: byte_next = startup_byte(STARTUP_FIRST);
                default:      byte_next = in_data.value;
            endcase
        end
        else if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.reg_select = rs_reg;
            out_next.nibble     = uop.hi_sel ? byte_reg[7:4] : byte_reg[3:0];
            out_next.enable     = uop.en;
            out_next.wait_ms    = uop.byte_end && init_reg && (idx_reg != STARTUP_FIRST);
            out_next.last       = uop.byte_end && !more_bytes;
            hold_next           = pulse_hold_reg - 1'b1;

            if (!uop.byte_end)
            begin
                pc_next = pc_reg + 2'd1;
            end
            else if (more_bytes)
            begin
                // conditional jump back to the first phase with the next byte
                pc_next   = 2'd0;
                idx_next  = idx_inc;
                byte_next = startup_byte(idx_inc);
            end
            else
            begin
                pc_next   = 2'd0;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pc_reg         <= 2'd0;
            init_reg       <= 1'b0;
            idx_reg        <= STARTUP_FIRST;
            hold_reg       <= '0;
            pulse_hold_reg <= PULSE_HOLD_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pc_reg         <= pc_next;
            init_reg       <= init_next;
            idx_reg        <= idx_next;
            hold_reg       <= hold_next;
            pulse_hold_reg <= pulse_hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
        out_reg  <= out_next;
    end

endmodule

// ----- sim/lcd_phase_checker.sv -----
`timescale 1ns / 1ps

module lcd_phase_checker
    import lcdseq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  lcdseq_in_t        in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  lcdseq_out_t       out_data,
    output int                fail_count,
    output int                pending
);

    // start-up bytes, first one in the top byte
    localparam logic [39:0] INIT_BYTES = {8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};
    // cursor row bases, row 0 in the low byte
    localparam logic [31:0] ROW_BASES  = {8'hD0, 8'h90, 8'hC0, 8'h80};
    localparam int          PRINT_CAP  = 40;

    lcdseq_out_t       pin_phase_q[$];

    // four pin phases per byte: high nibble EN 1/0, low nibble EN 1/0
    task automatic push_byte(input logic rs, input logic [7:0] b, input logic slow,
                             input logic fin);
        lcdseq_out_t ph;
        ph = '{reg_select: rs, nibble: b[7:4], enable: 1'b1, wait_ms: 1'b0, last: 1'b0};
        pin_phase_q.push_back(ph);
        ph.enable = 1'b0;
        pin_phase_q.push_back(ph);
        ph.nibble = b[3:0];
        ph.enable = 1'b1;
        pin_phase_q.push_back(ph);
        ph.enable  = 1'b0;
        ph.wait_ms = slow;
        ph.last    = fin;
        pin_phase_q.push_back(ph);
    endtask

    task automatic expand_request(input lcdseq_in_t req);
        case (req.func)
            FUNC_CMD:    push_byte(1'b0, req.value, 1'b0, 1'b1);
            FUNC_DATA:   push_byte(1'b1, req.value, 1'b0, 1'b1);
            FUNC_CURSOR: push_byte(1'b0, ROW_BASES[8*req.row +: 8] | {4'h0, req.col},
                                   1'b0, 1'b1);
            default:
                // extra wait after every start-up byte but the first
                for (int i = 0; i < 5; i++)
                    push_byte(1'b0, INIT_BYTES[8*(4-i) +: 8], i != 0, i == 4);
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lcdseq_out_t want;
        if (!rst_n)
        begin
            pin_phase_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expand_request(in_data);
            if (out_valid && !out_stall)
            begin
                if (pin_phase_q.size() == 0)
                    report_mismatch($sformatf("unexpected transaction rs=%b nib=%h en=%b",
                                              out_data.reg_select, out_data.nibble,
                                              out_data.enable));
                else
                begin
                    want = pin_phase_q.pop_front();
                    if (out_data.reg_select !== want.reg_select)
                        report_mismatch($sformatf("reg_select got %b want %b",
                                                  out_data.reg_select, want.reg_select));
                    if (out_data.nibble !== want.nibble)
                        report_mismatch($sformatf("nibble got %h want %h",
                                                  out_data.nibble, want.nibble));
                    if (out_data.enable !== want.enable)
                        report_mismatch($sformatf("enable got %b want %b",
                                                  out_data.enable, want.enable));
                    if (out_data.wait_ms !== want.wait_ms)
                        report_mismatch($sformatf("wait_ms got %b want %b",
                                                  out_data.wait_ms, want.wait_ms));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  out_data.last, want.last));
                end
            end
            pending = pin_phase_q.size();
        end
    end

endmodule

// ----- sim/tb_char_lcd_nibble_write_sequencer.sv -----
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer
    import lcdseq_pkg::*;
;

    localparam int                CYCLE_LIMIT     = 10_000_000;
    localparam int                HOLD_OFF_CYCLES = 400;
    localparam int                SETTLE_CYCLES   = 16;
    localparam logic [HOLD_W-1:0] HOLD_MAX        = '1;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    lcdseq_in_t        in_data   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [HOLD_W-1:0] cfg_data  = '0;
    logic              in_stall;
    logic              out_valid;
    lcdseq_out_t       out_data;
    logic              cfg_ready;

    int          fail_count;
    int          pending;
    int          cycles        = 0;
    int          burst_left    = 1;
    int          hold_off_reqs = 0;
    int          hold_off_done = 0;
    stall_mode_t stall_mode    = STALL_NONE;

    char_lcd_nibble_write_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lcd_phase_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise the current stall pattern
    initial
    begin : receiver
        int   run_left;
        logic run_stall;
        run_left  = 0;
        run_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_done != hold_off_reqs)
            begin
                out_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done++;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:   out_stall = 1'b0;
                    STALL_RANDOM: out_stall = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_stall = !run_stall;
                            run_left  = run_stall ? $urandom_range(1, 9) : $urandom_range(1, 6);
                        end
                        out_stall = run_stall;
                        run_left--;
                    end
                endcase
            end
        end
    end

    function automatic lcdseq_in_t make_request(input logic [1:0] f, input logic [7:0] v,
                                                input logic [1:0] r, input logic [3:0] c);
        return '{func: f, value: v, row: r, col: c};
    endfunction

    function automatic lcdseq_in_t random_request();
        lcdseq_in_t r;
        r.value = 8'($urandom_range(0, 255));
        r.row   = 2'($urandom_range(0, 3));
        r.col   = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       r.func = FUNC_STARTUP;
            1, 2, 3: r.func = FUNC_CMD;
            4, 5, 6: r.func = FUNC_DATA;
            default: r.func = FUNC_CURSOR;
        endcase
        return r;
    endfunction

    // entered and left at a falling edge; valid stays up within a burst
    task automatic send_request(input lcdseq_in_t req);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        in_valid = 1'b1;
        in_data  = req;
        do @(posedge clk); while (in_stall);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] ticks);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = ticks;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int count, input stall_mode_t mode, input bit squeeze);
        stall_mode = mode;
        for (int i = 0; i < count; i++)
        begin
            // receiver goes quiet while requests keep coming
            if (squeeze && i == 6)
                hold_off_reqs++;
            send_request(random_request());
        end
    endtask

    initial
    begin : main_seq
        lcdseq_in_t directed[$];
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one transaction at the reset hold time
        send_request(make_request(FUNC_DATA, 8'h41, 2'd0, 4'd0));
        write_hold(16'd1);

        directed.push_back(make_request(FUNC_CMD,     8'h00, 2'd0, 4'd0));
        directed.push_back(make_request(FUNC_CMD,     8'hFF, 2'd3, 4'd15));
        directed.push_back(make_request(FUNC_DATA,    8'h00, 2'd0, 4'd0));
        directed.push_back(make_request(FUNC_DATA,    8'hFF, 2'd3, 4'd15));
        directed.push_back(make_request(FUNC_DATA,    8'h5A, 2'd1, 4'd6));
        directed.push_back(make_request(FUNC_CMD,     8'hA5, 2'd2, 4'd9));
        directed.push_back(make_request(FUNC_CURSOR,  8'hFF, 2'd0, 4'd0));
        directed.push_back(make_request(FUNC_CURSOR,  8'h00, 2'd0, 4'd15));
        directed.push_back(make_request(FUNC_CURSOR,  8'hFF, 2'd1, 4'd0));
        directed.push_back(make_request(FUNC_CURSOR,  8'h00, 2'd1, 4'd15));
        directed.push_back(make_request(FUNC_CURSOR,  8'h00, 2'd2, 4'd0));
        directed.push_back(make_request(FUNC_CURSOR,  8'hFF, 2'd2, 4'd15));
        directed.push_back(make_request(FUNC_CURSOR,  8'h00, 2'd3, 4'd0));
        directed.push_back(make_request(FUNC_CURSOR,  8'hFF, 2'd3, 4'd15));
        directed.push_back(make_request(FUNC_STARTUP, 8'h00, 2'd0, 4'd0));
        directed.push_back(make_request(FUNC_STARTUP, 8'hFF, 2'd3, 4'd15));
        directed.push_back(make_request(FUNC_CMD,     8'h01, 2'd1, 4'd3));
        directed.push_back(make_request(FUNC_DATA,    8'h80, 2'd2, 4'd12));
        stall_mode = STALL_RANDOM;
        foreach (directed[i])
            send_request(directed[i]);

        write_hold(16'd2);
        run_random(40, STALL_RUNS, 1'b0);
        write_hold(16'd1);
        run_random(40, STALL_NONE, 1'b0);
        write_hold(16'd3);
        run_random(40, STALL_RUNS, 1'b1);
        write_hold(16'd7);
        run_random(40, STALL_RANDOM, 1'b0);
        write_hold(16'd1);
        run_random(40, STALL_RANDOM, 1'b1);

        // largest hold setting, a single byte transaction
        write_hold(HOLD_MAX);
        stall_mode = STALL_RANDOM;
        send_request(make_request(FUNC_CURSOR, 8'h00, 2'd3, 4'd15));
        settle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
